[sv/szlru_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package szlru_pkg;

    localparam int unsigned DEF_SLOTS = 16;
    localparam int unsigned MAX_SLOTS = 256;
    localparam int unsigned SLOT_IW   = $clog2(MAX_SLOTS);
    localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int unsigned TOT_W     = 32 + SLOT_IW;
    localparam int unsigned OUT_TOT_W = 36;

    localparam logic [1:0] REG_SIZE_LIMIT   = 2'd0;
    localparam logic [1:0] REG_LIMIT_ACTIVE = 2'd1;
    localparam logic [1:0] REG_CACHE_ENABLE = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_TRIM   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        RES_ADDED     = 3'd0,
        RES_REFRESHED = 3'd1,
        RES_REJECTED  = 3'd2,
        RES_EVICTED   = 3'd3,
        RES_DELETED   = 3'd4,
        RES_NOT_FOUND = 3'd5
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_CLEAR,
        PH_INSERT
    } phase_t;

    typedef enum logic [1:0] {
        WR_INVALIDATE,
        WR_INSERT,
        WR_STAMP
    } wr_kind_t;

    // write command broadcast to every cell
    typedef struct packed {
        logic               en;
        wr_kind_t           kind;
        logic [SLOT_IW-1:0] idx;
        logic [31:0]        id;
        logic [31:0]        size;
        logic [31:0]        stamp;
    } wr_t;

    // search token that walks the cell chain
    typedef struct packed {
        logic               active;
        logic               match_found;
        logic [SLOT_IW-1:0] match_idx;
        logic [31:0]        match_size;
        logic               free_found;
        logic [SLOT_IW-1:0] free_idx;
        logic               old_found;
        logic [SLOT_IW-1:0] old_idx;
        logic [31:0]        old_age;
        logic [31:0]        old_id;
        logic [31:0]        old_size;
        logic [CNT_W-1:0]   count;
    } scan_t;

endpackage

`default_nettype wire

[sv/szlru_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module szlru_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire szlru_pkg::wr_t   wr,
    input  wire logic [31:0]     key,
    input  wire logic [31:0]     now,
    input  wire szlru_pkg::scan_t carry_in,
    output szlru_pkg::scan_t      carry_out
);
    import szlru_pkg::*;

    localparam logic [SLOT_IW-1:0] MY_IDX = SLOT_IW'(IDX);

    logic        valid_reg;
    logic [31:0] id_reg;
    logic [31:0] size_reg;
    logic [31:0] stamp_reg;
    scan_t       carry_reg;
    scan_t       carry_next;
    logic [31:0] age;
    logic        hit;

    assign age = now - stamp_reg;
    assign hit = wr.en && (wr.idx == MY_IDX);

    always_comb
    begin
        carry_next = carry_in;
        if (valid_reg)
        begin
            carry_next.count = carry_in.count + CNT_W'(1);
            if (!carry_in.match_found && (id_reg == key))
            begin
                carry_next.match_found = 1'b1;
                carry_next.match_idx   = MY_IDX;
                carry_next.match_size  = size_reg;
            end
            // strict compare keeps the lower slot on a tie
            if (!carry_in.old_found || (age > carry_in.old_age))
            begin
                carry_next.old_found = 1'b1;
                carry_next.old_idx   = MY_IDX;
                carry_next.old_age   = age;
                carry_next.old_id    = id_reg;
                carry_next.old_size  = size_reg;
            end
        end
        else if (!carry_in.free_found)
        begin
            carry_next.free_found = 1'b1;
            carry_next.free_idx   = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
            if (hit)
            begin
                unique case (wr.kind)
                    WR_INVALIDATE: valid_reg <= 1'b0;
                    WR_INSERT:     valid_reg <= 1'b1;
                    WR_STAMP:      valid_reg <= valid_reg;
                    default:       valid_reg <= valid_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && (wr.kind == WR_INSERT))
        begin
            id_reg    <= wr.id;
            size_reg  <= wr.size;
            stamp_reg <= wr.stamp;
        end
        else if (hit && (wr.kind == WR_STAMP))
        begin
            stamp_reg <= wr.stamp;
        end
    end

    assign carry_out = carry_reg;

endmodule

`default_nettype wire

[sv/szlru_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module szlru_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [31:0]      cfg_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [1:0]       operation,
    input  wire logic [31:0]      item_id,
    input  wire logic [31:0]      item_size,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [2:0]            event_res,
    output logic [31:0]           event_id,
    output logic [35:0]           total_size,
    output logic                  last,
    output szlru_pkg::wr_t        wr,
    output logic [31:0]           key,
    output logic [31:0]           now,
    output logic                  scan_go,
    input  wire szlru_pkg::scan_t  chain_out
);
    import szlru_pkg::*;

    state_t      state_reg, state_next;
    phase_t      phase_reg;
    op_t         op_reg;
    logic [31:0] id_reg, size_reg, budget_reg, target_reg;
    logic        lim_reg;
    logic [TOT_W-1:0] total_reg;
    logic [31:0] clk_reg;
    scan_t       res_reg;
    logic        scan_go_reg;

    logic [31:0] size_limit_reg;
    logic        limit_active_reg, cache_enable_reg;

    logic        out_valid_reg, out_last_reg;
    res_t        out_res_reg;
    logic [31:0] out_id_reg;
    logic [OUT_TOT_W-1:0] out_total_reg;

    logic        accept, out_free, fire, need, more;
    logic        act_emit, act_last, act_tick;
    res_t        act_res;
    logic [31:0] act_id, act_target;
    logic [TOT_W-1:0] act_total, total_evict;
    state_t      act_go;
    phase_t      act_phase;
    wr_t         wr_cmd;

    assign accept   = (state_reg == ST_IDLE) && in_valid;
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = !act_emit || out_free;

    assign total_evict = total_reg - TOT_W'(res_reg.old_size);
    assign need = lim_reg && ((target_reg == 32'd0) || (total_reg > TOT_W'(target_reg)));
    assign more = ((target_reg == 32'd0) || (total_evict > TOT_W'(target_reg)))
                  && (res_reg.count > CNT_W'(1));

    // action taken on the latched scan result
    always_comb
    begin
        act_emit   = 1'b0;
        act_res    = RES_ADDED;
        act_id     = id_reg;
        act_last   = 1'b1;
        act_total  = total_reg;
        act_go     = ST_DECIDE;
        act_phase  = phase_reg;
        act_target = target_reg;
        act_tick   = 1'b0;
        wr_cmd     = '{en: 1'b0, kind: WR_STAMP, idx: '0, id: id_reg,
                       size: size_reg, stamp: clk_reg};
        unique case (op_reg)
            OP_ADD:
            begin
                unique case (phase_reg)
                    PH_FIRST:
                    begin
                        if (res_reg.match_found)
                        begin
                            wr_cmd.en   = 1'b1;
                            wr_cmd.kind = WR_STAMP;
                            wr_cmd.idx  = res_reg.match_idx;
                            act_tick    = 1'b1;
                            act_emit    = 1'b1;
                            act_res     = RES_REFRESHED;
                            act_go      = ST_IDLE;
                        end
                        else if (lim_reg && (size_reg > budget_reg))
                        begin
                            act_emit = 1'b1;
                            act_res  = RES_REJECTED;
                            act_go   = ST_IDLE;
                        end
                        else
                        begin
                            act_phase  = PH_CLEAR;
                            act_target = budget_reg - size_reg;
                        end
                    end
                    PH_CLEAR:
                    begin
                        if (need && res_reg.old_found)
                        begin
                            wr_cmd.en   = 1'b1;
                            wr_cmd.kind = WR_INVALIDATE;
                            wr_cmd.idx  = res_reg.old_idx;
                            act_total   = total_evict;
                            act_emit    = 1'b1;
                            act_res     = RES_EVICTED;
                            act_id      = res_reg.old_id;
                            act_last    = 1'b0;
                            act_go      = ST_SCAN;
                        end
                        else
                        begin
                            if (need)
                                act_total = '0;
                            act_phase = PH_INSERT;
                        end
                    end
                    PH_INSERT:
                    begin
                        if (res_reg.free_found)
                        begin
                            wr_cmd.en   = 1'b1;
                            wr_cmd.kind = WR_INSERT;
                            wr_cmd.idx  = res_reg.free_idx;
                            act_total   = total_reg + TOT_W'(size_reg);
                            act_tick    = 1'b1;
                            act_emit    = 1'b1;
                            act_res     = RES_ADDED;
                            act_go      = ST_IDLE;
                        end
                        else if (res_reg.old_found)
                        begin
                            // table full: drop the oldest, then rescan
                            wr_cmd.en   = 1'b1;
                            wr_cmd.kind = WR_INVALIDATE;
                            wr_cmd.idx  = res_reg.old_idx;
                            act_total   = total_evict;
                            act_emit    = 1'b1;
                            act_res     = RES_EVICTED;
                            act_id      = res_reg.old_id;
                            act_last    = 1'b0;
                            act_go      = ST_SCAN;
                        end
                        else
                        begin
                            act_go = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        act_go = ST_IDLE;
                    end
                endcase
            end
            OP_DELETE:
            begin
                act_emit = 1'b1;
                act_go   = ST_IDLE;
                if (res_reg.match_found)
                begin
                    wr_cmd.en   = 1'b1;
                    wr_cmd.kind = WR_INVALIDATE;
                    wr_cmd.idx  = res_reg.match_idx;
                    act_total   = total_reg - TOT_W'(res_reg.match_size);
                    act_res     = RES_DELETED;
                end
                else
                begin
                    act_res = RES_NOT_FOUND;
                end
            end
            OP_TRIM:
            begin
                act_go = ST_IDLE;
                if (need && res_reg.old_found)
                begin
                    wr_cmd.en   = 1'b1;
                    wr_cmd.kind = WR_INVALIDATE;
                    wr_cmd.idx  = res_reg.old_idx;
                    act_total   = total_evict;
                    act_emit    = 1'b1;
                    act_res     = RES_EVICTED;
                    act_id      = res_reg.old_id;
                    act_last    = !more;
                    act_go      = more ? ST_SCAN : ST_IDLE;
                end
                else if (need)
                begin
                    act_total = '0;
                end
            end
            OP_NONE:
            begin
                act_go = ST_IDLE;
            end
            default:
            begin
                act_go = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if ((op_t'(operation) == OP_ADD) || (op_t'(operation) == OP_DELETE))
                        state_next = ST_SCAN;
                    else if ((op_t'(operation) == OP_TRIM) && limit_active_reg)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (chain_out.active)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (fire)
                    state_next = act_go;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr    = wr_cmd;
        wr.en = wr_cmd.en && fire && (state_reg == ST_DECIDE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_FIRST;
            total_reg        <= '0;
            clk_reg          <= '0;
            scan_go_reg      <= 1'b0;
            size_limit_reg   <= '0;
            limit_active_reg <= 1'b0;
            cache_enable_reg <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            scan_go_reg <= (state_next == ST_SCAN) && (state_reg != ST_SCAN);
            if (cfg_we)
            begin
                if (cfg_index == REG_SIZE_LIMIT)
                    size_limit_reg <= cfg_data;
                else if (cfg_index == REG_LIMIT_ACTIVE)
                    limit_active_reg <= cfg_data[0];
                else if (cfg_index == REG_CACHE_ENABLE)
                    cache_enable_reg <= cfg_data[0];
            end
            if (accept)
            begin
                phase_reg <= (op_t'(operation) == OP_TRIM) ? PH_CLEAR : PH_FIRST;
            end
            else if ((state_reg == ST_DECIDE) && fire)
            begin
                phase_reg <= act_phase;
                total_reg <= act_total;
                if (act_tick)
                    clk_reg <= clk_reg + 32'd1;
            end
            if ((state_reg == ST_DECIDE) && fire && act_emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op_t'(operation);
            id_reg     <= item_id;
            size_reg   <= item_size;
            lim_reg    <= limit_active_reg;
            budget_reg <= cache_enable_reg ? size_limit_reg : 32'd0;
            target_reg <= cache_enable_reg ? size_limit_reg : 32'd0;
        end
        else if ((state_reg == ST_DECIDE) && fire)
        begin
            target_reg <= act_target;
        end
        if ((state_reg == ST_SCAN) && chain_out.active)
            res_reg <= chain_out;
        if ((state_reg == ST_DECIDE) && fire && act_emit)
        begin
            out_res_reg   <= act_res;
            out_id_reg    <= act_id;
            out_last_reg  <= act_last;
            out_total_reg <= (act_total[TOT_W-1:OUT_TOT_W] != '0)
                             ? {OUT_TOT_W{1'b1}} : act_total[OUT_TOT_W-1:0];
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign event_res  = out_res_reg;
    assign event_id   = out_id_reg;
    assign total_size = out_total_reg;
    assign last       = out_last_reg;
    assign key        = id_reg;
    assign now        = clk_reg;
    assign scan_go    = scan_go_reg;

endmodule

`default_nettype wire

[sv/size_budget_lru_cache_top.sv]
// Size-budgeted LRU table built as a chain of SLOTS slot cells.
// Every search walks the chain from start to decision.
// A delete, refresh or reject decides on one search; an add takes further decision steps,
// and each eviction of an add starts a new search. Output stalls hold the decision.
// One item at a time: the next item can be taken in the cycle after the final decision.
// Async active-low reset empties the table, zeroes total and use clock.
`timescale 1ns / 1ps
`default_nettype none

module size_budget_lru_cache_top #(
    parameter int unsigned SLOTS = szlru_pkg::DEF_SLOTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] item_id,
    input  wire logic [31:0] item_size,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       event_res,
    output logic [31:0]      event_id,
    output logic [35:0]      total_size,
    output logic             last
);
    import szlru_pkg::*;

    wr_t         wr;
    logic [31:0] key;
    logic [31:0] now;
    logic        scan_go;
    scan_t       chain [SLOTS+1];

    always_comb
    begin
        chain[0]        = '0;
        chain[0].active = scan_go;
    end

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        szlru_cell #(.IDX(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr        (wr),
            .key       (key),
            .now       (now),
            .carry_in  (chain[i]),
            .carry_out (chain[i+1])
        );
    end

    szlru_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .item_id    (item_id),
        .item_size  (item_size),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_res  (event_res),
        .event_id   (event_id),
        .total_size (total_size),
        .last       (last),
        .wr         (wr),
        .key        (key),
        .now        (now),
        .scan_go    (scan_go),
        .chain_out  (chain[SLOTS])
    );

`ifndef SYNTHESIS
    // no slot is modified while a search token is injected
    a_no_write_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !scan_go)
        else $error("slot write during scan start");

    // an add or delete always keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && ((operation == OP_ADD) || (operation == OP_DELETE)))
        |=> in_stall)
        else $error("block not busy after add or delete");

    // a search result reaches the end of the chain only while busy
    a_chain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain[SLOTS].active |-> in_stall)
        else $error("scan result while idle");
`endif

endmodule

`default_nettype wire

[verif/size_budget_lru_cache_top_tb.sv]
`timescale 1ns / 1ps

module size_budget_lru_cache_top_tb;
    import szlru_pkg::*;

    localparam int NSLOT = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_WAIT = 4 * NSLOT + 20;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [31:0] item_id;
    logic [31:0] item_size;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  event_res;
    logic [31:0] event_id;
    logic [35:0] total_size;
    logic        last;

    size_budget_lru_cache_top #(.SLOTS(NSLOT)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .item_id(item_id), .item_size(item_size),
        .out_valid(out_valid), .out_stall(out_stall),
        .event_res(event_res), .event_id(event_id),
        .total_size(total_size), .last(last)
    );

    typedef struct {
        res_t        res;
        logic [31:0] id;
        logic [35:0] total;
        logic        last;
    } cache_event_t;

    cache_event_t pending_events[$];
    int errors = 0;
    int cycles = 0;
    res_t first_res;

    // shadow of the table
    logic [31:0]     m_limit;
    logic            m_active;
    logic            m_enable;
    bit              m_valid[NSLOT];
    logic [31:0]     m_id[NSLOT];
    logic [31:0]     m_size[NSLOT];
    logic [31:0]     m_stamp[NSLOT];
    longint unsigned m_total;
    logic [31:0]     m_clock;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("size_budget_lru_cache_top_tb failed");
            $finish;
        end
    end

    function automatic void note_event(res_t r, logic [31:0] id);
        cache_event_t e;
        e.res   = r;
        e.id    = id;
        e.total = (m_total > 64'hF_FFFF_FFFF) ? 36'hF_FFFF_FFFF : m_total[35:0];
        e.last  = 1'b0;
        pending_events.push_back(e);
    endfunction

    function automatic bit evict_lru();
        int best;
        logic [31:0] best_age;
        logic [31:0] age;
        best = -1;
        best_age = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (m_valid[i])
            begin
                age = m_clock - m_stamp[i];
                if (best < 0 || age > best_age)
                begin
                    best = i;
                    best_age = age;
                end
            end
        end
        if (best < 0)
            return 0;
        m_valid[best] = 0;
        m_total -= m_size[best];
        note_event(RES_EVICTED, m_id[best]);
        return 1;
    endfunction

    function automatic void shrink_to(longint unsigned target);
        while (target == 0 || m_total > target)
        begin
            if (!evict_lru())
            begin
                m_total = 0;
                break;
            end
        end
    endfunction

    function automatic int find_slot(logic [31:0] id);
        for (int i = 0; i < NSLOT; i++)
            if (m_valid[i] && m_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < NSLOT; i++)
            if (!m_valid[i])
                return i;
        return -1;
    endfunction

    // returns number of events queued for this beat
    function automatic int apply_cache_op(op_t op, logic [31:0] id, logic [31:0] sz);
        longint unsigned budget;
        int before_n;
        int s;
        before_n = pending_events.size();
        budget = m_enable ? longint'(m_limit) : 0;
        if (op == OP_ADD)
        begin
            s = find_slot(id);
            if (s >= 0)
            begin
                m_stamp[s] = m_clock;
                m_clock = m_clock + 1;
                note_event(RES_REFRESHED, id);
            end
            else if (m_active && longint'(sz) > budget)
                note_event(RES_REJECTED, id);
            else
            begin
                if (m_active)
                    shrink_to(budget - longint'(sz));
                s = free_slot();
                if (s < 0)
                begin
                    void'(evict_lru());
                    s = free_slot();
                end
                if (s >= 0)
                begin
                    m_valid[s] = 1;
                    m_id[s] = id;
                    m_size[s] = sz;
                    m_stamp[s] = m_clock;
                    m_clock = m_clock + 1;
                    m_total += sz;
                    note_event(RES_ADDED, id);
                end
            end
        end
        else if (op == OP_DELETE)
        begin
            s = find_slot(id);
            if (s >= 0)
            begin
                m_valid[s] = 0;
                m_total -= m_size[s];
                note_event(RES_DELETED, id);
            end
            else
                note_event(RES_NOT_FOUND, id);
        end
        else if (op == OP_TRIM)
        begin
            if (m_active)
                shrink_to(budget);
        end
        if (pending_events.size() > before_n)
            pending_events[$].last = 1'b1;
        return pending_events.size() - before_n;
    endfunction

    // result checker and receiver stall pattern
    int stall_mode = 0;
    always @(posedge clk)
    begin
        cache_event_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat: res=%0d id=%h total=%h last=%b",
                                 event_res, event_id, total_size, last);
                end
                else
                begin
                    e = pending_events.pop_front();
                    if (event_res !== e.res || event_id !== e.id ||
                        total_size !== e.total || last !== e.last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp %0d %h %h %b, got %0d %h %h %b",
                                     e.res, e.id, e.total, e.last,
                                     event_res, event_id, total_size, last);
                    end
                end
            end
            if (cycles % 64 == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 2) == 0);
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    int burst_left = 0;

    task automatic send_beat(op_t op, logic [31:0] id, logic [31:0] sz, output int n);
        in_valid  <= 1'b1;
        operation <= op;
        item_id   <= id;
        item_size <= sz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n = apply_cache_op(op, id, sz);
        if (n > 0)
            first_res = pending_events[pending_events.size() - n].res;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SIZE_LIMIT:   m_limit  = data;
            REG_LIMIT_ACTIVE: m_active = data[0];
            REG_CACHE_ENABLE: m_enable = data[0];
            default: ;
        endcase
    endtask

    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        op_t         op;
        logic [31:0] id;
        logic [31:0] sz;
        bit          typed;
        res_t        res;
    } step_row_t;

    step_row_t plan[$];

    function automatic void add_row(bit is_cfg, logic [1:0] ri, op_t op, logic [31:0] id,
                                    logic [31:0] sz, bit typed, res_t res);
        step_row_t r;
        r.is_cfg = is_cfg; r.reg_idx = ri; r.op = op; r.id = id; r.sz = sz;
        r.typed = typed; r.res = res;
        plan.push_back(r);
    endfunction

    initial
    begin
        int n;
        op_t op;
        logic [31:0] id;
        logic [31:0] sz;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_SIZE_LIMIT;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        operation <= OP_ADD;
        item_id   <= '0;
        item_size <= '0;
        out_stall <= 1'b0;
        m_limit = 0; m_active = 0; m_enable = 1;
        m_total = 0; m_clock = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            m_valid[i] = 0; m_id[i] = 0; m_size[i] = 0; m_stamp[i] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(0, REG_SIZE_LIMIT, OP_ADD,    32'h0,        32'h0,        1, RES_ADDED);
        add_row(0, REG_SIZE_LIMIT, OP_ADD,    32'hFFFFFFFF, 32'hFFFFFFFF, 1, RES_ADDED);
        add_row(0, REG_SIZE_LIMIT, OP_ADD,    32'h0,        32'h5,        1, RES_REFRESHED);
        add_row(0, REG_SIZE_LIMIT, OP_DELETE, 32'h12345,    32'h0,        1, RES_NOT_FOUND);
        add_row(0, REG_SIZE_LIMIT, OP_DELETE, 32'hFFFFFFFF, 32'h0,        1, RES_DELETED);
        add_row(0, REG_SIZE_LIMIT, OP_NONE,   32'h1,        32'h1,        0, RES_ADDED);
        add_row(0, REG_SIZE_LIMIT, OP_TRIM,   32'h0,        32'h0,        0, RES_ADDED);
        add_row(1, REG_SIZE_LIMIT,   OP_ADD,  32'd100,      0, 0, RES_ADDED);
        add_row(1, REG_LIMIT_ACTIVE, OP_ADD,  32'd1,        0, 0, RES_ADDED);
        add_row(0, REG_SIZE_LIMIT, OP_ADD,    32'h7,        32'd200,      1, RES_REJECTED);
        add_row(0, REG_SIZE_LIMIT, OP_ADD,    32'h1,        32'd30,       0, RES_ADDED);
        add_row(0, REG_SIZE_LIMIT, OP_ADD,    32'h2,        32'd30,       0, RES_ADDED);
        add_row(0, REG_SIZE_LIMIT, OP_ADD,    32'h3,        32'd30,       0, RES_ADDED);
        add_row(0, REG_SIZE_LIMIT, OP_ADD,    32'h4,        32'd50,       0, RES_ADDED);
        add_row(1, REG_SIZE_LIMIT,   OP_ADD,  32'd40,       0, 0, RES_ADDED);
        add_row(0, REG_SIZE_LIMIT, OP_TRIM,   32'h0,        32'h0,        0, RES_ADDED);
        // size equal to budget clears everything, zero-size items too
        add_row(0, REG_SIZE_LIMIT, OP_ADD,    32'h5,        32'd40,       0, RES_ADDED);
        add_row(1, REG_CACHE_ENABLE, OP_ADD,  32'd0,        0, 0, RES_ADDED);
        add_row(0, REG_SIZE_LIMIT, OP_ADD,    32'h9,        32'd0,        0, RES_ADDED);
        add_row(0, REG_SIZE_LIMIT, OP_TRIM,   32'h0,        32'h0,        0, RES_ADDED);
        add_row(0, REG_SIZE_LIMIT, OP_ADD,    32'h9,        32'd1,        1, RES_REJECTED);
        add_row(1, REG_CACHE_ENABLE, OP_ADD,  32'd1,        0, 0, RES_ADDED);
        add_row(1, REG_SIZE_LIMIT,   OP_ADD,  32'hFFFFFFFF, 0, 0, RES_ADDED);
        add_row(0, REG_SIZE_LIMIT, OP_ADD,    32'hA,        32'hFFFFFFFF, 1, RES_ADDED);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].reg_idx, plan[i].id);
            else
            begin
                send_beat(plan[i].op, plan[i].id, plan[i].sz, n);
                if (plan[i].typed && (n == 0 || first_res != plan[i].res))
                begin
                    errors++;
                    if (errors <= 10)
                        $display("directed row %0d: expected res %0d", i, plan[i].res);
                end
            end
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: write_reg(REG_SIZE_LIMIT, $urandom_range(0, 200));
                1: write_reg(REG_SIZE_LIMIT, 32'hFFFFFFFF);
                2: write_reg(REG_SIZE_LIMIT, 32'h0);
                default: write_reg(REG_SIZE_LIMIT, $urandom_range(20, 600));
            endcase
            write_reg(REG_LIMIT_ACTIVE, (ph == 1) ? 32'd0 : 32'd1);
            write_reg(REG_CACHE_ENABLE, (ph == 5) ? 32'd0 : 32'd1);
            for (int k = 0; k < 30; k++)
            begin
                n = $urandom_range(0, 99);
                if (n < 60)      op = OP_ADD;
                else if (n < 85) op = OP_DELETE;
                else if (n < 95) op = OP_TRIM;
                else             op = OP_NONE;
                id = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 23);
                n = $urandom_range(0, 9);
                if (n == 0)      sz = $urandom;
                else if (n == 1) sz = 0;
                else             sz = $urandom_range(1, 60);
                send_beat(op, id, sz, n);
            end
        end

        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
        if (errors == 0)
            $display("size_budget_lru_cache_top_tb passed");
        else
            $display("size_budget_lru_cache_top_tb failed");
        $finish;
    end

endmodule

[filelist.f]
sv/szlru_pkg.sv
sv/szlru_cell.sv
sv/szlru_ctrl.sv
sv/size_budget_lru_cache_top.sv
verif/size_budget_lru_cache_top_tb.sv
